@@ hdl/c2s_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared types, widths and constants of the Cartesian to spherical converter.
// ----------------------------------------------------------------------------
package c2s_pkg;

    localparam int unsigned COORD_W     = 24;
    localparam int unsigned RAD_W       = 24;
    localparam int unsigned AZ_W        = 25;
    localparam int unsigned POL_W       = 24;
    localparam int unsigned SQ_W        = 48;
    localparam int unsigned ANG_W       = 26;
    localparam int unsigned CIN_W       = 34;
    localparam int unsigned CW          = 64;
    localparam int unsigned SCALE_SHIFT = 28;
    localparam int unsigned SQRT_W      = 64;
    localparam int unsigned ROOT_W      = SQRT_W / 2;
    localparam int unsigned FIFO_DEPTH  = 8;
    localparam int unsigned FIFO_AW     = 3;
    localparam int unsigned FIFO_CW     = 4;
    localparam int unsigned FRONT_DEPTH = 3;

    localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;
    localparam logic signed [ANG_W-1:0] AZ_MIN = -26'sd11796479;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic        [SQ_W-1:0]    sum_r;
        logic        [SQ_W-1:0]    sum_t;
    } t_item;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [FIFO_CW-1:0] count;
    } t_fifo_stat;

    function automatic logic signed [ANG_W-1:0] atan_deg(input int unsigned idx);
        logic signed [ANG_W-1:0] v;
        begin
            case (idx)
                0:       v = 26'sd2949120;
                1:       v = 26'sd1740967;
                2:       v = 26'sd919879;
                3:       v = 26'sd466945;
                4:       v = 26'sd234379;
                5:       v = 26'sd117304;
                6:       v = 26'sd58666;
                7:       v = 26'sd29335;
                8:       v = 26'sd14668;
                9:       v = 26'sd7334;
                10:      v = 26'sd3667;
                11:      v = 26'sd1833;
                12:      v = 26'sd917;
                13:      v = 26'sd458;
                14:      v = 26'sd229;
                15:      v = 26'sd115;
                16:      v = 26'sd57;
                17:      v = 26'sd29;
                18:      v = 26'sd14;
                19:      v = 26'sd7;
                20:      v = 26'sd4;
                21:      v = 26'sd2;
                22:      v = 26'sd1;
                default: v = 26'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ hdl/cartesian_to_spherical.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Converts signed Q15.8 points to radius, azimuth and polar angle in degrees.
//
// Channel   Direction  Handshake            Payload
// command   in         start / busy         i_x_coord, i_y_coord, i_z_coord
// result    out        o_strobe (1 cycle)   o_radius, o_azimuth_deg, o_polar_deg
//
// One point per clock while busy is low. A point passes through two front
// stages, the queue, a 33-stage square root, a CORDIC pipeline of
// ITERATIONS + 1 stages and one output register.
// Reset is synchronous and clears every valid bit; results leave without stalls,
// so busy rises only if the queue ever holds FIFO_DEPTH - FRONT_DEPTH points.
// ----------------------------------------------------------------------------
module cartesian_to_spherical #(
    parameter int ITERATIONS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [c2s_pkg::COORD_W-1:0]  i_x_coord,
    input  logic signed [c2s_pkg::COORD_W-1:0]  i_y_coord,
    input  logic signed [c2s_pkg::COORD_W-1:0]  i_z_coord,
    output logic                                o_strobe,
    output logic        [c2s_pkg::RAD_W-1:0]    o_radius,
    output logic signed [c2s_pkg::AZ_W-1:0]     o_azimuth_deg,
    output logic        [c2s_pkg::POL_W-1:0]    o_polar_deg
);
    import c2s_pkg::*;

    logic       accept, push;
    t_item      front_item, head_item;
    t_fifo_stat fifo_stat;

    assign busy   = (fifo_stat.count >= FIFO_CW'(FIFO_DEPTH - FRONT_DEPTH));
    assign accept = start && !busy;

    c2s_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_x     (i_x_coord),
        .i_y     (i_y_coord),
        .i_z     (i_z_coord),
        .o_push  (push),
        .o_item  (front_item)
    );

    c2s_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (!fifo_stat.empty),
        .o_item  (head_item),
        .o_stat  (fifo_stat)
    );

    c2s_back #(.ITERATIONS(ITERATIONS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (!fifo_stat.empty),
        .i_item        (head_item),
        .o_strobe      (o_strobe),
        .o_radius      (o_radius),
        .o_azimuth_deg (o_azimuth_deg),
        .o_polar_deg   (o_polar_deg)
    );

endmodule

@@ hdl/c2s_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_front
// Accepts points, squares the coordinates and forms the two sums of squares.
// ----------------------------------------------------------------------------
module c2s_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic signed [c2s_pkg::COORD_W-1:0] i_x,
    input  logic signed [c2s_pkg::COORD_W-1:0] i_y,
    input  logic signed [c2s_pkg::COORD_W-1:0] i_z,
    output logic                               o_push,
    output c2s_pkg::t_item                     o_item
);
    import c2s_pkg::*;

    logic                      r_v1;
    logic signed [COORD_W-1:0] r_x1, r_y1, r_z1;
    logic                      r_v2;
    logic signed [COORD_W-1:0] r_x2, r_y2, r_z2;
    logic        [SQ_W-2:0]    r_xx, r_yy, r_zz;
    logic signed [SQ_W-1:0]    n_xx, n_yy, n_zz;

    always_comb begin
        n_xx = r_x1 * r_x1;
        n_yy = r_y1 * r_y1;
        n_zz = r_z1 * r_z1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_x1 <= i_x;
        r_y1 <= i_y;
        r_z1 <= i_z;
        r_x2 <= r_x1;
        r_y2 <= r_y1;
        r_z2 <= r_z1;
        r_xx <= n_xx[SQ_W-2:0];
        r_yy <= n_yy[SQ_W-2:0];
        r_zz <= n_zz[SQ_W-2:0];
    end

    always_comb begin
        o_push       = r_v2;
        o_item.x     = r_x2;
        o_item.y     = r_y2;
        o_item.z     = r_z2;
        o_item.sum_t = {1'b0, r_xx} + {1'b0, r_yy};
        o_item.sum_r = o_item.sum_t + {1'b0, r_zz};
    end

endmodule

@@ hdl/c2s_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_fifo
// Show-ahead queue between the front and back parts.
// ----------------------------------------------------------------------------
module c2s_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  c2s_pkg::t_item      i_item,
    input  logic                i_pop,
    output c2s_pkg::t_item      o_item,
    output c2s_pkg::t_fifo_stat o_stat
);
    import c2s_pkg::*;

    t_item               r_mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0]  r_wptr, r_rptr;
    logic [FIFO_CW-1:0]  r_count;
    logic                do_push, do_pop;

    always_comb begin
        o_stat.empty = (r_count == '0);
        o_stat.full  = (r_count == FIFO_CW'(FIFO_DEPTH));
        o_stat.count = r_count;
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        o_item       = r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

@@ hdl/c2s_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_isqrt
// Pipelined floor square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module c2s_isqrt #(
    parameter int W      = 64,
    parameter int SIDE_W = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [W-1:0]      i_n,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [W/2-1:0]    o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int RW = W / 2;

    logic              r_v    [0:RW];
    logic [W-1:0]      r_rem  [0:RW];
    logic [RW-1:0]     r_root [0:RW];
    logic [SIDE_W-1:0] r_side [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rem[0]  <= i_n;
        r_root[0] <= '0;
        r_side[0] <= i_side;
    end

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;
        logic [W+1:0] trial;
        logic         take;

        always_comb begin
            trial = (({{(W+2-RW){1'b0}}, r_root[k]}) << (B + 1))
                  + ((W+2)'(1) << (2 * B));
            take  = ({2'b00, r_rem[k]} >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_side[k+1] <= r_side[k];
            if (take) begin
                r_rem[k+1]  <= r_rem[k] - trial[W-1:0];
                r_root[k+1] <= r_root[k] | (RW'(1) << B);
            end else begin
                r_rem[k+1]  <= r_rem[k];
                r_root[k+1] <= r_root[k];
            end
        end
    end

    assign o_valid = r_v[RW];
    assign o_root  = r_root[RW];
    assign o_side  = r_side[RW];

endmodule

@@ hdl/c2s_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_cordic
// Pipelined CORDIC vectoring, atan2 in Q16 degrees, with sideband.
// ----------------------------------------------------------------------------
module c2s_cordic #(
    parameter int ITERATIONS = 16,
    parameter int SIDE_W     = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic signed [c2s_pkg::CIN_W-1:0]      i_yv,
    input  logic signed [c2s_pkg::CIN_W-1:0]      i_xv,
    input  logic        [SIDE_W-1:0]              i_side,
    output logic                                  o_valid,
    output logic signed [c2s_pkg::ANG_W-1:0]      o_angle,
    output logic        [SIDE_W-1:0]              o_side
);
    import c2s_pkg::*;

    logic                    r_v    [0:ITERATIONS];
    logic                    r_sp   [0:ITERATIONS];
    logic signed [CW-1:0]    r_cx   [0:ITERATIONS];
    logic signed [CW-1:0]    r_cy   [0:ITERATIONS];
    logic signed [ANG_W-1:0] r_ang  [0:ITERATIONS];
    logic [SIDE_W-1:0]       r_side [0:ITERATIONS];

    logic signed [CW-1:0]    cx0, cy0, n_cx, n_cy;
    logic signed [ANG_W-1:0] n_ang;
    logic                    n_sp;

    always_comb begin
        cx0   = {{(CW-CIN_W){i_xv[CIN_W-1]}}, i_xv} <<< SCALE_SHIFT;
        cy0   = {{(CW-CIN_W){i_yv[CIN_W-1]}}, i_yv} <<< SCALE_SHIFT;
        n_cx  = cx0;
        n_cy  = cy0;
        n_ang = '0;
        n_sp  = 1'b0;
        priority if (i_yv == '0) begin
            n_sp  = 1'b1;
            n_ang = i_xv[CIN_W-1] ? DEG180 : '0;
        end else if (i_xv == '0) begin
            n_sp  = 1'b1;
            n_ang = i_yv[CIN_W-1] ? -DEG90 : DEG90;
        end else if (i_xv[CIN_W-1]) begin
            if (!i_yv[CIN_W-1]) begin
                n_cx  = cy0;
                n_cy  = -cx0;
                n_ang = DEG90;
            end else begin
                n_cx  = -cy0;
                n_cy  = cx0;
                n_ang = -DEG90;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_sp[0]   <= n_sp;
        r_cx[0]   <= n_cx;
        r_cy[0]   <= n_cy;
        r_ang[0]  <= n_ang;
        r_side[0] <= i_side;
    end

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
        localparam logic signed [ANG_W-1:0] STEP = atan_deg(g);
        logic signed [CW-1:0] dx, dy;

        always_comb begin
            dx = r_cy[g] >>> g;
            dy = r_cx[g] >>> g;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
            r_sp[g+1]   <= r_sp[g];
            r_side[g+1] <= r_side[g];
            if (r_cy[g] > 0) begin
                r_cx[g+1] <= r_cx[g] + dx;
                r_cy[g+1] <= r_cy[g] - dy;
            end else begin
                r_cx[g+1] <= r_cx[g] - dx;
                r_cy[g+1] <= r_cy[g] + dy;
            end
            priority if (r_sp[g]) begin
                r_ang[g+1] <= r_ang[g];
            end else if (r_cy[g] > 0) begin
                r_ang[g+1] <= r_ang[g] + STEP;
            end else begin
                r_ang[g+1] <= r_ang[g] - STEP;
            end
        end
    end

    assign o_valid = r_v[ITERATIONS];
    assign o_angle = r_ang[ITERATIONS];
    assign o_side  = r_side[ITERATIONS];

endmodule

@@ hdl/c2s_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_back
// Square roots, two CORDIC passes and output saturation.
// ----------------------------------------------------------------------------
module c2s_back #(
    parameter int ITERATIONS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  c2s_pkg::t_item                      i_item,
    output logic                                o_strobe,
    output logic        [c2s_pkg::RAD_W-1:0]    o_radius,
    output logic signed [c2s_pkg::AZ_W-1:0]     o_azimuth_deg,
    output logic        [c2s_pkg::POL_W-1:0]    o_polar_deg
);
    import c2s_pkg::*;

    logic                      v_r, v_t, v_th, v_ph;
    logic [ROOT_W-1:0]         root_r, rho;
    logic [2*COORD_W-1:0]      xy_d;
    logic [COORD_W-1:0]        z_d;
    logic signed [COORD_W-1:0] x_d, y_d, zs_d;
    logic [RAD_W-1:0]          rad_r;
    logic [RAD_W-1:0]          rad_th, rad_ph;
    logic signed [ANG_W-1:0]   ang_th, ang_ph;
    logic signed [ANG_W-1:0]   n_az, n_pol;

    logic                      r_strobe;
    logic [RAD_W-1:0]          r_radius;
    logic signed [AZ_W-1:0]    r_az;
    logic [POL_W-1:0]          r_pol;

    c2s_isqrt #(.W(SQRT_W), .SIDE_W(2*COORD_W)) u_sqrt_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_n     ({{(SQRT_W-SQ_W){1'b0}}, i_item.sum_r}),
        .i_side  ({i_item.x, i_item.y}),
        .o_valid (v_r),
        .o_root  (root_r),
        .o_side  (xy_d)
    );

    c2s_isqrt #(.W(SQRT_W), .SIDE_W(COORD_W)) u_sqrt_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_n     ({i_item.sum_t, {(SQRT_W-SQ_W){1'b0}}}),
        .i_side  (i_item.z),
        .o_valid (v_t),
        .o_root  (rho),
        .o_side  (z_d)
    );

    always_comb begin
        x_d   = xy_d[2*COORD_W-1:COORD_W];
        y_d   = xy_d[COORD_W-1:0];
        zs_d  = z_d;
        rad_r = root_r[RAD_W-1:0];
    end

    c2s_cordic #(.ITERATIONS(ITERATIONS), .SIDE_W(RAD_W)) u_cordic_az (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_r && v_t),
        .i_yv    ({{2{y_d[COORD_W-1]}}, y_d, 8'b0}),
        .i_xv    ({{2{x_d[COORD_W-1]}}, x_d, 8'b0}),
        .i_side  (rad_r),
        .o_valid (v_th),
        .o_angle (ang_th),
        .o_side  (rad_th)
    );

    c2s_cordic #(.ITERATIONS(ITERATIONS), .SIDE_W(RAD_W)) u_cordic_pol (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_r && v_t),
        .i_yv    ({2'b00, rho}),
        .i_xv    ({{2{zs_d[COORD_W-1]}}, zs_d, 8'b0}),
        .i_side  (rad_r),
        .o_valid (v_ph),
        .o_angle (ang_ph),
        .o_side  (rad_ph)
    );

    always_comb begin
        priority if (ang_th > DEG180) begin
            n_az = DEG180;
        end else if (ang_th < AZ_MIN) begin
            n_az = AZ_MIN;
        end else begin
            n_az = ang_th;
        end
        priority if (rad_ph == '0) begin
            n_pol = '0;
        end else if (ang_ph < 0) begin
            n_pol = '0;
        end else if (ang_ph > DEG180) begin
            n_pol = DEG180;
        end else begin
            n_pol = ang_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= v_th && v_ph;
        end
        r_radius <= rad_th;
        r_az     <= n_az[AZ_W-1:0];
        r_pol    <= n_pol[POL_W-1:0];
    end

    assign o_strobe      = r_strobe;
    assign o_radius      = r_radius;
    assign o_azimuth_deg = r_az;
    assign o_polar_deg   = r_pol;

endmodule

@@ hdl/c2s_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module c2s_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_strobe,
    input logic        [c2s_pkg::RAD_W-1:0]    o_radius,
    input logic signed [c2s_pkg::AZ_W-1:0]     o_azimuth_deg,
    input logic        [c2s_pkg::POL_W-1:0]    o_polar_deg
);
    import c2s_pkg::*;

    logic unused_start;
    assign unused_start = start;

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe && !busy)
        else $error("result or busy after reset");

    a_polar_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_polar_deg <= POL_W'(DEG180))
        else $error("polar angle above 180 degrees");

    a_az_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_azimuth_deg <= AZ_W'(DEG180)) && (o_azimuth_deg >= AZ_W'(AZ_MIN)))
        else $error("azimuth out of range");

    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_radius == '0) |-> (o_azimuth_deg == '0) && (o_polar_deg == '0))
        else $error("origin gives nonzero angle");

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_radius      (o_radius),
    .o_azimuth_deg (o_azimuth_deg),
    .o_polar_deg   (o_polar_deg)
);
